@@ hw/rtl/ftn_address_parser_unit_assert.svh @@
// Assertion macros shared by the checker files of the address parser.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef FTN_ADDRESS_PARSER_UNIT_ASSERT_SVH
`define FTN_ADDRESS_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTN_AP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftn_ap: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTN_AP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftn_ap: next-cycle check failed");

`endif

@@ hw/rtl/ftn_ap_pkg.sv @@
// Package of the address parser: part encoding, characters, register map,
// parse phases and shared structs. No dependencies.
package ftn_ap_pkg;

    localparam int NUMBER_BITS_DEF = 16;
    localparam int PART_W          = 17;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic [PART_W-1:0] PART_EMPTY = 17'h1FFFF;
    localparam logic [PART_W-1:0] PART_WILD  = 17'h1FFFE;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LW    = 8'h77;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Whole-word candidates
    localparam int CAND_STAR  = 0;
    localparam int CAND_ALL   = 1;
    localparam int CAND_WORLD = 2;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_FILL_MODE = 2'd0;
    localparam logic [1:0] REG_PREV_ZONE = 2'd1;
    localparam logic [1:0] REG_PREV_NET  = 2'd2;
    localparam logic [1:0] REG_PREV_NODE = 2'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_NUM_START,
        PH_DIGITS,
        PH_A,
        PH_AL,
        PH_DONE,
        PH_DOMAIN
    } phase_t;

    typedef struct packed {
        logic              empty;
        logic [PART_W-1:0] val;
    } part_t;

    localparam part_t PART_NONE = '{empty: 1'b1, val: PART_EMPTY};

    typedef struct packed {
        logic  err;
        logic  all_wild;
        part_t zone;
        part_t net;
        part_t node;
        part_t point;
        logic  dom;
    } raw_res_t;

    typedef struct packed {
        logic              fill_mode;
        logic [PART_W-1:0] prev_zone;
        logic [PART_W-1:0] prev_net;
        logic [PART_W-1:0] prev_node;
    } cfg_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPA && c <= CH_UPZ)
            r = c | CASE_BIT;
        return r;
    endfunction

    function automatic logic char_is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] all_char(input logic [1:0] pos);
        logic [7:0] r;
        unique case (pos)
            2'd0:    r = CH_LA;
            default: r = CH_LL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] world_char(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = CH_LW;
            3'd1:    r = CH_LO;
            3'd2:    r = CH_LR;
            3'd3:    r = CH_LL;
            default: r = CH_LD;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/ftn_address_parser_unit.sv @@
// Address parser, one character per request. A result is registered once its
// last character leaves the input register. Throughput: 1 character per cycle
// unless a last character waits for the result register to have space; the
// input and result registers let a new character enter while a result waits.
// Reset (rst_n low, asynchronous): parser at start of string, both registers
// empty, fill_mode 0, previous zone/net/node -1. Depends on ftn_ap_pkg.
module ftn_address_parser_unit
    import ftn_ap_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    // character requests
    input  logic                     char_valid,
    output logic                     char_ready,
    input  logic [7:0]               char_in,
    input  logic                     last_char,

    // parsed addresses
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     parse_ok,
    output logic signed [PART_W-1:0] zone_out,
    output logic signed [PART_W-1:0] net_out,
    output logic signed [PART_W-1:0] node_out,
    output logic signed [PART_W-1:0] point_out,
    output logic                     has_domain
);

    cfg_t       cfg;
    raw_res_t   raw;
    logic       space;
    logic       step;
    logic       take;
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // Input register. A held character advances into the parser unless it is
    // the last of a string and the result register cannot take the result;
    // only then does the request channel stall.
    assign step       = in_valid_reg && (!last_reg || space);
    assign char_ready = !in_valid_reg || step;
    assign take       = char_valid && char_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    // Payload needs no reset: it is only looked at while in_valid_reg is set
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_in;
            last_reg <= last_char;
        end
    end

    ftn_ap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Parse state advances on every character step and clears after the last
    ftn_ap_parser #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step),
        .char_in   (char_reg),
        .last_char (last_reg),
        .raw       (raw)
    );

    // Only the last character of a string produces a result
    ftn_ap_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && last_reg),
        .raw          (raw),
        .cfg          (cfg),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .parse_ok     (parse_ok),
        .zone_out     (zone_out),
        .net_out      (net_out),
        .node_out     (node_out),
        .point_out    (point_out),
        .has_domain   (has_domain)
    );

endmodule

@@ hw/rtl/ftn_ap_regs.sv @@
// APB configuration registers: fill mode and the previous address parts.
// Depends on ftn_ap_pkg.
module ftn_ap_regs
    import ftn_ap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_mode <= 1'b0;
            cfg_reg.prev_zone <= PART_EMPTY;
            cfg_reg.prev_net  <= PART_EMPTY;
            cfg_reg.prev_node <= PART_EMPTY;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FILL_MODE: cfg_reg.fill_mode <= pwdata[0];
                REG_PREV_ZONE: cfg_reg.prev_zone <= pwdata[PART_W-1:0];
                REG_PREV_NET:  cfg_reg.prev_net  <= pwdata[PART_W-1:0];
                REG_PREV_NODE: cfg_reg.prev_node <= pwdata[PART_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sign-extend the part registers on read
    always_comb
    begin
        unique case (reg_idx)
            REG_FILL_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.fill_mode};
            REG_PREV_ZONE: prdata = {{(DATA_W-PART_W){cfg_reg.prev_zone[PART_W-1]}},
                                     cfg_reg.prev_zone};
            REG_PREV_NET:  prdata = {{(DATA_W-PART_W){cfg_reg.prev_net[PART_W-1]}},
                                     cfg_reg.prev_net};
            REG_PREV_NODE: prdata = {{(DATA_W-PART_W){cfg_reg.prev_node[PART_W-1]}},
                                     cfg_reg.prev_node};
            default:       prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/ftn_ap_parser.sv @@
// Per-character parse state and its next-state logic, including the
// whole-word wildcard tracker. Depends on ftn_ap_pkg.
module ftn_ap_parser
    import ftn_ap_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output raw_res_t   raw
);

    typedef struct packed {
        phase_t                 phase;
        logic [1:0]             idx;
        logic [NUMBER_BITS-1:0] acc;
        part_t                  zone;
        part_t                  net;
        part_t                  node;
        part_t                  point;
        logic                   dom;
        logic                   err;
    } pstate_t;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;
    localparam pstate_t ST_CLEAR = '{
        phase: PH_START, idx: 2'd0, acc: '0,
        zone: PART_NONE, net: PART_NONE, node: PART_NONE, point: PART_NONE,
        dom: 1'b0, err: 1'b0
    };

    pstate_t                st_reg, st_next, work, fin;
    logic [2:0]             mpos_reg, mpos_next;
    logic [2:0]             mcand_reg, mcand_next;
    logic [7:0]             lc;
    logic                   dig;
    logic [NUMBER_BITS+3:0] mul10;
    logic                   sat;

    // A number or wildcard has ended; place it by the separator that follows.
    function automatic pstate_t finish_num(input pstate_t s, input logic [7:0] sep,
                                           input logic is_end);
        pstate_t r;
        part_t   v;
        logic    adv;
        r       = s;
        adv     = 1'b0;
        v.empty = 1'b0;
        v.val   = (s.phase == PH_DONE) ? PART_WILD : PART_W'(s.acc);
        unique case (s.idx)
            2'd0:
            begin
                priority if (!is_end && sep == CH_COLON)
                begin
                    r.zone = v;
                    r.idx  = 2'd1;
                    adv    = 1'b1;
                end
                else if (!is_end && sep == CH_SLASH)
                begin
                    r.net = v;
                    r.idx = 2'd2;
                    adv   = 1'b1;
                end
                else
                begin
                    r.node = v;
                    if (!is_end && sep == CH_DOT)
                    begin
                        r.idx = 2'd3;
                        adv   = 1'b1;
                    end
                end
            end
            2'd1:
            begin
                r.net = v;
                priority if (!is_end && sep == CH_SLASH)
                begin
                    r.idx = 2'd2;
                    adv   = 1'b1;
                end
                else if (!is_end && sep == CH_DOT)
                begin
                    r.idx = 2'd3;
                    adv   = 1'b1;
                end
                else
                begin
                end
            end
            2'd2:
            begin
                r.node = v;
                if (!is_end && sep == CH_DOT)
                begin
                    r.idx = 2'd3;
                    adv   = 1'b1;
                end
            end
            default:
            begin
                r.point = v;
            end
        endcase
        priority if (adv)
        begin
            r.phase = PH_NUM_START;
            r.acc   = '0;
        end
        else if (!is_end && sep == CH_AT)
        begin
            r.dom   = 1'b1;
            r.phase = PH_DOMAIN;
        end
        else if (!is_end)
        begin
            r.err = 1'b1;
        end
        else
        begin
        end
        return r;
    endfunction

    assign lc    = to_lower(char_in);
    assign dig   = char_is_num(char_in);
    assign mul10 = ({4'b0, st_reg.acc} << 3) + ({4'b0, st_reg.acc} << 1)
                 + {{NUMBER_BITS{1'b0}}, char_in[3:0]};
    assign sat   = |mul10[NUMBER_BITS+3:NUMBER_BITS];

    // Character step
    always_comb
    begin
        work = st_reg;
        if (!st_reg.err)
        begin
            if (st_reg.phase == PH_START && char_in == CH_DOT)
            begin
                work.idx   = 2'd3;
                work.phase = PH_NUM_START;
            end
            else
            begin
                if (st_reg.phase == PH_START)
                begin
                    work.idx   = 2'd0;
                    work.phase = PH_NUM_START;
                end
                unique case (work.phase)
                    PH_NUM_START:
                    begin
                        priority if (char_in == CH_STAR)
                            work.phase = PH_DONE;
                        else if (lc == CH_LA)
                            work.phase = PH_A;
                        else if (dig)
                        begin
                            work.acc   = NUMBER_BITS'(char_in[3:0]);
                            work.phase = PH_DIGITS;
                        end
                        else
                            work.err = 1'b1;
                    end
                    PH_A:
                    begin
                        if (lc == CH_LL)
                            work.phase = PH_AL;
                        else
                            work.err = 1'b1;
                    end
                    PH_AL:
                    begin
                        if (lc == CH_LL)
                            work.phase = PH_DONE;
                        else
                            work.err = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (dig)
                            work.acc = sat ? NUM_MAX : mul10[NUMBER_BITS-1:0];
                        else
                            work = finish_num(work, char_in, 1'b0);
                    end
                    PH_DONE:
                    begin
                        work = finish_num(work, char_in, 1'b0);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // End of string: close an open number, anything else unfinished is bad
        fin = work;
        if (!work.err)
        begin
            priority if (work.phase == PH_DIGITS || work.phase == PH_DONE)
                fin = finish_num(work, 8'h00, 1'b1);
            else if (work.phase != PH_DOMAIN)
                fin.err = 1'b1;
            else
            begin
            end
        end

        st_next = last_char ? ST_CLEAR : work;
    end

    // Whole-word tracker for "*", "all" and "world"
    always_comb
    begin
        mcand_next = mcand_reg;
        if (!(mpos_reg == 3'd0 && char_in == CH_STAR))
            mcand_next[CAND_STAR] = 1'b0;
        if (!(mpos_reg < 3'd3 && lc == all_char(mpos_reg[1:0])))
            mcand_next[CAND_ALL] = 1'b0;
        if (!(mpos_reg < 3'd5 && lc == world_char(mpos_reg)))
            mcand_next[CAND_WORLD] = 1'b0;
        mpos_next = (mpos_reg == 3'd7) ? mpos_reg : mpos_reg + 3'd1;
    end

    assign raw.err      = fin.err;
    assign raw.all_wild = (mcand_next[CAND_STAR]  && mpos_next == 3'd1)
                       || (mcand_next[CAND_ALL]   && mpos_next == 3'd3)
                       || (mcand_next[CAND_WORLD] && mpos_next == 3'd5);
    assign raw.zone     = fin.zone;
    assign raw.net      = fin.net;
    assign raw.node     = fin.node;
    assign raw.point    = fin.point;
    assign raw.dom      = fin.dom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_CLEAR;
            mpos_reg  <= 3'd0;
            mcand_reg <= 3'b111;
        end
        else if (step_en)
        begin
            st_reg    <= st_next;
            mpos_reg  <= last_char ? 3'd0 : mpos_next;
            mcand_reg <= last_char ? 3'b111 : mcand_next;
        end
    end

endmodule

@@ hw/rtl/ftn_ap_result.sv @@
// Result register: formats the end-of-string parse (wildcard, error, fill
// from the previous address) and holds it for the result channel. Uses ftn_ap_pkg.
module ftn_ap_result
    import ftn_ap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  raw_res_t                 raw,
    input  cfg_t                     cfg,
    output logic                     space,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     parse_ok,
    output logic signed [PART_W-1:0] zone_out,
    output logic signed [PART_W-1:0] net_out,
    output logic signed [PART_W-1:0] node_out,
    output logic signed [PART_W-1:0] point_out,
    output logic                     has_domain
);

    logic              valid_reg;
    logic              ok_reg, ok_next;
    logic [PART_W-1:0] zone_reg, zone_next;
    logic [PART_W-1:0] net_reg, net_next;
    logic [PART_W-1:0] node_reg, node_next;
    logic [PART_W-1:0] point_reg, point_next;
    logic              dom_reg, dom_next;

    assign space = !valid_reg || result_ready;

    always_comb
    begin
        ok_next    = 1'b1;
        zone_next  = raw.zone.val;
        net_next   = raw.net.val;
        node_next  = raw.node.val;
        point_next = raw.point.val;
        dom_next   = raw.dom;
        priority if (raw.all_wild)
        begin
            zone_next  = PART_WILD;
            net_next   = PART_WILD;
            node_next  = PART_WILD;
            point_next = PART_WILD;
            dom_next   = 1'b0;
        end
        else if (raw.err)
        begin
            ok_next    = 1'b0;
            zone_next  = '0;
            net_next   = '0;
            node_next  = '0;
            point_next = '0;
            dom_next   = 1'b0;
        end
        else if (cfg.fill_mode && raw.zone.empty)
        begin
            // cascade: net and node fill only while the part above was empty
            zone_next = cfg.prev_zone;
            if (raw.net.empty)
            begin
                net_next = cfg.prev_net;
                if (raw.node.empty)
                    node_next = cfg.prev_node;
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg    <= ok_next;
            zone_reg  <= zone_next;
            net_reg   <= net_next;
            node_reg  <= node_next;
            point_reg <= point_next;
            dom_reg   <= dom_next;
        end
    end

    assign result_valid = valid_reg;
    assign parse_ok     = ok_reg;
    assign zone_out     = zone_reg;
    assign net_out      = net_reg;
    assign node_out     = node_reg;
    assign point_out    = point_reg;
    assign has_domain   = dom_reg;

endmodule

@@ hw/rtl/ftn_ap_checker.sv @@
// Port-level checks of the address parser, bound to the top level.
// Depends on ftn_address_parser_unit_assert.svh and ftn_ap_pkg.
`include "ftn_address_parser_unit_assert.svh"

module ftn_ap_checker
    import ftn_ap_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     char_valid,
    input logic                     char_ready,
    input logic                     last_char,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic                     parse_ok,
    input logic signed [PART_W-1:0] zone_out,
    input logic signed [PART_W-1:0] net_out,
    input logic signed [PART_W-1:0] node_out,
    input logic signed [PART_W-1:0] point_out,
    input logic                     has_domain
);

    // A stalled result holds its payload
    `FTN_AP_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(parse_ok) && $stable(zone_out) && $stable(net_out) && $stable(node_out) && $stable(point_out) && $stable(has_domain))

    // A syntax error carries all-zero parts and no domain
    `FTN_AP_ASSERT_IMP(a_error_zero, clk, rst_n, result_valid && !parse_ok, zone_out == '0 && net_out == '0 && node_out == '0 && point_out == '0 && !has_domain)

    // A result appearing from empty follows an accepted last character
    `FTN_AP_ASSERT_IMP(a_result_source, clk, rst_n, $rose(result_valid), $past(char_valid && char_ready && last_char, 2))

    // Requests stall only behind a pending result
    `FTN_AP_ASSERT_IMP(a_stall_cause, clk, rst_n, !char_ready, result_valid)

endmodule

bind ftn_address_parser_unit ftn_ap_checker u_ftn_ap_checker (.*);

@@ verif/ftn_address_parser_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench for ftn_address_parser_unit: streams address strings one character per
// request, predicts each parsed address in-line and checks the result channel.
// Depends on ftn_ap_pkg and the ftn_address_parser_unit RTL only.
module ftn_address_parser_unit_test;
    import ftn_ap_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;      // margin for the result register to drain
    localparam int IDLE_PCT     = 34;
    localparam int NUM_LIMIT    = (1 << NUMBER_BITS_DEF) - 1;
    localparam int SEP_END      = -1;     // end of string seen as a separator
    localparam logic [23:0] ALL_TXT   = {CH_LA, CH_LL, CH_LL};
    localparam logic [39:0] WORLD_TXT = {CH_LW, CH_LO, CH_LR, CH_LL, CH_LD};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    typedef struct packed {
        logic              ok;
        logic [PART_W-1:0] zone;
        logic [PART_W-1:0] net;
        logic [PART_W-1:0] node;
        logic [PART_W-1:0] point;
        logic              dom;
    } addr_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     char_valid = 1'b0;
    logic                     char_ready;
    logic [7:0]               char_in = '0;
    logic                     last_char = 1'b0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic                     parse_ok;
    logic signed [PART_W-1:0] zone_out;
    logic signed [PART_W-1:0] net_out;
    logic signed [PART_W-1:0] node_out;
    logic signed [PART_W-1:0] point_out;
    logic                     has_domain;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ftn_address_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_in      (char_in),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .parse_ok     (parse_ok),
        .zone_out     (zone_out),
        .net_out      (net_out),
        .node_out     (node_out),
        .point_out    (point_out),
        .has_domain   (has_domain)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared by the driver, the monitor and the stimulus
    // ------------------------------------------------------------------
    char_req_t    pending_chars[$];    // requests not yet presented
    addr_result_t expected_addrs[$];   // parsed addresses still to arrive
    logic [7:0]   text_buf[$];         // string under construction
    int           cycles = 0;
    int           chars_queued = 0;
    int           chars_taken = 0;
    int           addrs_seen = 0;
    int           addrs_ok = 0;
    int           settings_applied = 0;
    int           err_count = 0;
    logic         calm;

    // Both sides run flat out for a stretch in the middle of the run.
    assign calm = (chars_taken >= 300) && (chars_taken < 450);

    // ------------------------------------------------------------------
    // Parser model: configuration copy and per-string parse state
    // ------------------------------------------------------------------
    logic              cfg_fill = 1'b0;
    logic [PART_W-1:0] cfg_zone = PART_EMPTY;
    logic [PART_W-1:0] cfg_net  = PART_EMPTY;
    logic [PART_W-1:0] cfg_node = PART_EMPTY;

    phase_t            ps_phase;
    int                ps_part;     // 0 leading, 1 net, 2 node, 3 point, 4 none left
    int                ps_acc;
    logic [PART_W-1:0] ps_zone, ps_net, ps_node, ps_point;
    logic              ps_dom;
    logic              ps_err;
    int                wm_pos;      // whole-word tracker: position, saturates at 7
    logic              wm_star, wm_all, wm_world;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= CH_UPA && c <= CH_UPZ) ? (c ^ CASE_BIT) : c;
    endfunction

    function automatic void clear_parse();
        ps_phase = PH_START;
        ps_part  = 0;
        ps_acc   = 0;
        ps_zone  = PART_EMPTY;
        ps_net   = PART_EMPTY;
        ps_node  = PART_EMPTY;
        ps_point = PART_EMPTY;
        ps_dom   = 1'b0;
        ps_err   = 1'b0;
        wm_pos   = 0;
        wm_star  = 1'b1;
        wm_all   = 1'b1;
        wm_world = 1'b1;
    endfunction

    // A number or wildcard part has ended; sep is the following character or SEP_END.
    function automatic void close_part(input int sep);
        logic [PART_W-1:0] val;
        int                nxt;
        logic              advance;
        val     = (ps_phase == PH_DONE) ? PART_WILD : ps_acc[PART_W-1:0];
        nxt     = 4;
        advance = 1'b0;
        case (ps_part)
            0:
            begin
                // a leading number is zone before ':', net before '/', else node
                if (sep == CH_COLON)
                begin
                    ps_zone = val;
                    nxt = 1;
                end
                else if (sep == CH_SLASH)
                begin
                    ps_net = val;
                    nxt = 2;
                end
                else
                begin
                    ps_node = val;
                    if (sep == CH_DOT)
                        nxt = 3;
                end
                advance = (nxt != 4);
            end
            1:
            begin
                ps_net = val;
                if (sep == CH_SLASH)
                    nxt = 2;
                else if (sep == CH_DOT)
                    nxt = 3;
                advance = (nxt != 4);
            end
            2:
            begin
                ps_node = val;
                nxt = 3;
                advance = (sep == CH_DOT);
            end
            default:
                ps_point = val;
        endcase
        if (advance)
        begin
            ps_part  = nxt;
            ps_phase = PH_NUM_START;
            ps_acc   = 0;
        end
        else if (sep == CH_AT)
        begin
            ps_dom   = 1'b1;
            ps_phase = PH_DOMAIN;
        end
        else if (sep != SEP_END)
            ps_err = 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [7:0] lc;
        logic       digit;
        lc    = fold_case(c);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (ps_phase == PH_START)
        begin
            // a leading dot opens a point-only address
            if (c == CH_DOT)
            begin
                ps_part  = 3;
                ps_phase = PH_NUM_START;
                return;
            end
            ps_part  = 0;
            ps_phase = PH_NUM_START;
        end
        case (ps_phase)
            PH_NUM_START:
            begin
                if (c == CH_STAR)
                    ps_phase = PH_DONE;
                else if (lc == CH_LA)
                    ps_phase = PH_A;
                else if (digit)
                begin
                    ps_acc   = int'(c) - int'(CH_ZERO);
                    ps_phase = PH_DIGITS;
                end
                else
                    ps_err = 1'b1;
            end
            PH_A:
                if (lc == CH_LL)
                    ps_phase = PH_AL;
                else
                    ps_err = 1'b1;
            PH_AL:
                if (lc == CH_LL)
                    ps_phase = PH_DONE;
                else
                    ps_err = 1'b1;
            PH_DIGITS:
            begin
                if (digit)
                begin
                    ps_acc = ps_acc * 10 + (int'(c) - int'(CH_ZERO));
                    if (ps_acc > NUM_LIMIT)
                        ps_acc = NUM_LIMIT;
                end
                else
                    close_part(int'(c));
            end
            PH_DONE:
                close_part(int'(c));
            default:
                ;   // domain text: accept anything
        endcase
    endfunction

    // Track whether the whole string is "*", "all" or "world".
    function automatic void match_word(input logic [7:0] c);
        logic [7:0] lc;
        lc = fold_case(c);
        if (!(wm_pos == 0 && c == CH_STAR))
            wm_star = 1'b0;
        if (wm_pos < 3)
        begin
            if (lc != ALL_TXT[23 - 8 * wm_pos -: 8])
                wm_all = 1'b0;
        end
        else
            wm_all = 1'b0;
        if (wm_pos < 5)
        begin
            if (lc != WORLD_TXT[39 - 8 * wm_pos -: 8])
                wm_world = 1'b0;
        end
        else
            wm_world = 1'b0;
        if (wm_pos < 7)
            wm_pos++;
    endfunction

    // Advance the model by one character; returns 1 with the parsed address
    // when the character closes a string.
    function automatic logic parse_step(input logic [7:0] c, input logic last,
                                        output addr_result_t r);
        logic whole;
        match_word(c);
        if (!ps_err)
            scan_char(c);
        if (!last)
            return 1'b0;
        if (!ps_err)
        begin
            if (ps_phase == PH_DIGITS || ps_phase == PH_DONE)
                close_part(SEP_END);
            else if (ps_phase != PH_DOMAIN)
                ps_err = 1'b1;
        end
        whole = (wm_star && wm_pos == 1) || (wm_all && wm_pos == 3) ||
                (wm_world && wm_pos == 5);
        r = '0;
        if (whole)
        begin
            // global wildcard overrides errors and fill mode
            r.ok    = 1'b1;
            r.zone  = PART_WILD;
            r.net   = PART_WILD;
            r.node  = PART_WILD;
            r.point = PART_WILD;
        end
        else if (!ps_err)
        begin
            r.ok    = 1'b1;
            r.zone  = ps_zone;
            r.net   = ps_net;
            r.node  = ps_node;
            r.point = ps_point;
            r.dom   = ps_dom;
            // fill cascades: zone first, then net, then node
            if (cfg_fill && r.zone == PART_EMPTY)
            begin
                r.zone = cfg_zone;
                if (r.net == PART_EMPTY)
                begin
                    r.net = cfg_net;
                    if (r.node == PART_EMPTY)
                        r.node = cfg_node;
                end
            end
        end
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued characters, predict at each accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_req_t    req;
        addr_result_t res;
        if (!rst_n)
            char_valid <= 1'b0;
        else
        begin
            if (char_valid && char_ready)
            begin
                chars_taken++;
                if (parse_step(char_in, last_char, res))
                    expected_addrs.push_back(res);
            end
            // hold the payload until it is taken; only then advance or drop valid
            if (!char_valid || char_ready)
            begin
                if (pending_chars.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    req = pending_chars.pop_front();
                    char_valid <= 1'b1;
                    char_in    <= req.ch;
                    last_char  <= req.last;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result channel at random, check every result
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [PART_W-1:0] want,
                               input logic [PART_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        addr_result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                addrs_seen++;
                if (parse_ok === 1'b1)
                    addrs_ok++;
                if (expected_addrs.size() == 0)
                begin
                    $error("parsed address arrived with none expected");
                    err_count++;
                end
                else
                begin
                    want = expected_addrs.pop_front();
                    check_field("parse_ok", PART_W'(want.ok), PART_W'(parse_ok));
                    check_field("zone_out", want.zone, zone_out);
                    check_field("net_out", want.net, net_out);
                    check_field("node_out", want.node, node_out);
                    check_field("point_out", want.point, point_out);
                    check_field("has_domain", PART_W'(want.dom), PART_W'(has_domain));
                end
            end
            result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic void add_num(input int v);
        add_text($sformatf("%0d", v));
    endfunction

    // Letters of the word flip case at random.
    function automatic void add_case_word(input string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (ch != CH_STAR && $urandom_range(1) == 1)
                ch = ch ^ CASE_BIT;
            text_buf.push_back(ch);
        end
    endfunction

    // Turn the buffer into requests, marking the final character.
    function automatic void send_text();
        char_req_t req;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            req.ch   = text_buf[i];
            req.last = (i == text_buf.size() - 1);
            pending_chars.push_back(req);
            chars_queued++;
        end
        text_buf.delete();
    endfunction

    function automatic logic [7:0] noise_char();
        string      letters;
        logic [7:0] ch;
        letters = "alwdorALWDOR";
        case ($urandom_range(7))
            0:       ch = CH_ZERO + 8'($urandom_range(9));
            1:       ch = CH_COLON;
            2:       ch = CH_SLASH;
            3:       ch = CH_DOT;
            4:       ch = CH_AT;
            5:       ch = CH_STAR;
            6:       ch = letters[$urandom_range(11)];
            default: ch = 8'($urandom_range(255));
        endcase
        return ch;
    endfunction

    // One part: mostly small numbers, with wildcards, extremes and overflow.
    function automatic void add_part();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            text_buf.push_back(CH_STAR);
        else if (sel < 18)
            add_case_word("all");
        else if (sel < 24)
            add_num(0);
        else if (sel < 30)
            add_num(NUM_LIMIT);
        else if (sel < 36)
            add_num($urandom_range(9999999, NUM_LIMIT + 1));
        else if (sel < 42)
        begin
            add_text("00");
            add_num($urandom_range(999));
        end
        else if (sel < 70)
            add_num($urandom_range(99));
        else
            add_num($urandom_range(NUM_LIMIT));
    endfunction

    // Well-formed address in one of the legal shapes, optional domain.
    function automatic void add_address();
        int shape;
        shape = $urandom_range(6);
        if (shape <= 1)
        begin
            add_part();
            text_buf.push_back(CH_COLON);
        end
        if (shape <= 3)
        begin
            add_part();
            text_buf.push_back(CH_SLASH);
        end
        if (shape != 6)
            add_part();
        if (shape == 0 || shape == 3 || shape == 5 || shape == 6)
        begin
            text_buf.push_back(CH_DOT);
            add_part();
        end
        if ($urandom_range(99) < 25)
        begin
            text_buf.push_back(CH_AT);
            repeat ($urandom_range(5))
                text_buf.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_random_string();
        int kind;
        int idx;
        kind = $urandom_range(99);
        if (kind < 6)
        begin
            case ($urandom_range(2))
                0:       add_case_word("*");
                1:       add_case_word("all");
                default: add_case_word("world");
            endcase
        end
        else if (kind < 72)
            add_address();
        else if (kind < 86)
        begin
            // break a good address: overwrite or insert one character
            add_address();
            idx = $urandom_range(text_buf.size() - 1);
            if ($urandom_range(1) == 1)
                text_buf[idx] = noise_char();
            else
                text_buf.insert(idx, noise_char());
        end
        else
            repeat ($urandom_range(8, 1))
                text_buf.push_back(noise_char());
        send_text();
    endfunction

    function automatic int pick_prev();
        int v;
        case ($urandom_range(4))
            0:       v = -2;
            1:       v = -1;
            2:       v = 0;
            3:       v = NUM_LIMIT;
            default: v = $urandom_range(NUM_LIMIT);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------
    // Wait until every request is taken and every address has come back.
    task automatic wait_idle();
        while (pending_chars.size() != 0 || char_valid || expected_addrs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic fill, input int z, input int n, input int f);
        wait_idle();
        apb_write(REG_FILL_MODE, int'(fill));
        apb_write(REG_PREV_ZONE, z);
        apb_write(REG_PREV_NET, n);
        apb_write(REG_PREV_NODE, f);
        cfg_fill = fill;
        cfg_zone = z[PART_W-1:0];
        cfg_net  = n[PART_W-1:0];
        cfg_node = f[PART_W-1:0];
        settings_applied++;
    endtask

    task automatic run_random(input int count);
        int base;
        base = chars_queued;
        while (chars_queued - base < count)
            add_random_string();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings under the reset configuration.
        add_text("1:2/3.4");                send_text();
        add_text("65535:0/99999.00007");    send_text();   // saturation
        add_text("*");                      send_text();   // global wildcard
        add_text("aLL");                    send_text();
        add_text("WoRlD");                  send_text();
        add_text("*:All/*.*");              send_text();   // wildcard parts
        add_text(".5");                     send_text();   // point only
        add_text("1:2/3.4@net");            send_text();
        add_text("4@");
        text_buf.push_back(8'h00);                         // NUL inside a domain
        text_buf.push_back(8'hFF);          send_text();
        text_buf.push_back(8'h00);          send_text();   // NUL alone is an error
        text_buf.push_back(8'hFF);          send_text();
        add_text(".");                      send_text();
        add_text("1.2.3");                  send_text();   // separators out of order
        add_text("1/2:3");                  send_text();
        add_text("world1");                 send_text();
        add_text("*x");                     send_text();   // text after a wildcard
        add_text("al");                     send_text();
        add_text("5:");                     send_text();

        // Fill mode: empty leading parts come from the previous address.
        apply_setting(1'b1, 1, 2, 3);
        add_text("7");                      send_text();
        add_text("2/3");                    send_text();
        add_text(".4");                     send_text();
        add_text("9:8/7");                  send_text();
        run_random(120);

        apply_setting(1'b1, -2, -2, -2);
        run_random(120);
        apply_setting(1'b1, NUM_LIMIT, 0, NUM_LIMIT);
        run_random(120);
        apply_setting(1'b1, -1, -1, -1);
        run_random(120);
        apply_setting(1'b0, pick_prev(), pick_prev(), pick_prev());
        run_random(120);
        apply_setting(1'b1, pick_prev(), pick_prev(), pick_prev());
        run_random(120);

        wait_idle();
        $display("Sent %0d characters over %0d register settings plus reset defaults.",
                 chars_taken, settings_applied);
        $display("Checked %0d addresses: %0d parsed, %0d rejected.",
                 addrs_seen, addrs_ok, addrs_seen - addrs_ok);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ftn_ap_pkg.sv
hw/rtl/ftn_ap_regs.sv
hw/rtl/ftn_ap_parser.sv
hw/rtl/ftn_ap_result.sv
hw/rtl/ftn_address_parser_unit.sv
hw/rtl/ftn_ap_checker.sv
verif/ftn_address_parser_unit_test.sv
